@@ design/stl_pkg.sv @@
// Types, codes and character helpers for the Scheme token lexer.
// No dependencies; imported by scheme_token_lexer_top.
package stl_pkg;

   // Lexer mode
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_NUM     = 3'd1,
      MODE_STR     = 3'd2,
      MODE_HASH    = 3'd3,
      MODE_SYM     = 3'd4,
      MODE_COMMENT = 3'd5
   } mode_type;

   // Result kinds
   localparam logic [2:0] KIND_OPEN   = 3'd0;
   localparam logic [2:0] KIND_CLOSE  = 3'd1;
   localparam logic [2:0] KIND_INT    = 3'd2;
   localparam logic [2:0] KIND_FLOAT  = 3'd3;
   localparam logic [2:0] KIND_STRING = 3'd4;
   localparam logic [2:0] KIND_SYMBOL = 3'd5;
   localparam logic [2:0] KIND_BOOL   = 3'd6;
   localparam logic [2:0] KIND_END    = 3'd7;

   // Line status on line end
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_OPEN_STR = 2'd2;

   // Character codes
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_UP_T   = 8'h54;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_LO_L   = 8'h6C;
   localparam logic [7:0] CH_LO_R   = 8'h72;
   localparam logic [7:0] CH_LO_S   = 8'h73;
   localparam logic [7:0] CH_LO_T   = 8'h74;
   localparam logic [7:0] CH_LO_U   = 8'h75;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_CR     = 8'd13;

   // Boolean word matcher states
   localparam logic [3:0] BM_NONE  = 4'd0;
   localparam logic [3:0] BM_HASH  = 4'd1;
   localparam logic [3:0] BM_F     = 4'd2;
   localparam logic [3:0] BM_UF    = 4'd3;
   localparam logic [3:0] BM_T     = 4'd4;
   localparam logic [3:0] BM_UT    = 4'd5;
   localparam logic [3:0] BM_FA    = 4'd6;
   localparam logic [3:0] BM_FAL   = 4'd7;
   localparam logic [3:0] BM_FALS  = 4'd8;
   localparam logic [3:0] BM_FALSE = 4'd9;
   localparam logic [3:0] BM_TR    = 4'd10;
   localparam logic [3:0] BM_TRU   = 4'd11;
   localparam logic [3:0] BM_TRUE  = 4'd12;

   // One result transaction
   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] int_value;
      logic               bool_value;
      logic [7:0]         start_column;
      logic [8:0]         token_length;
      logic [1:0]         line_status;
      logic               last;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return is_space(c) || (c == CH_OPEN) || (c == CH_CLOSE) ||
             (c == CH_QUOTE) || (c == CH_SEMI);
   endfunction

   // Step the #true / #false matcher by one character
   function automatic logic [3:0] next_match(input logic [3:0] s, input logic [7:0] c);
      logic [3:0] n;
      n = BM_NONE;
      case (s)
         BM_HASH: begin
            if (c == CH_LO_F)      n = BM_F;
            else if (c == CH_UP_F) n = BM_UF;
            else if (c == CH_LO_T) n = BM_T;
            else if (c == CH_UP_T) n = BM_UT;
         end
         BM_F:    if (c == CH_LO_A) n = BM_FA;
         BM_FA:   if (c == CH_LO_L) n = BM_FAL;
         BM_FAL:  if (c == CH_LO_S) n = BM_FALS;
         BM_FALS: if (c == CH_LO_E) n = BM_FALSE;
         BM_T:    if (c == CH_LO_R) n = BM_TR;
         BM_TR:   if (c == CH_LO_U) n = BM_TRU;
         BM_TRU:  if (c == CH_LO_E) n = BM_TRUE;
         default: n = BM_NONE;
      endcase
      return n;
   endfunction

endpackage

@@ design/scheme_token_lexer_top.sv @@
// Scheme token lexer: one character per transaction in, tokens out.
// Depends on stl_pkg (types, codes, character helpers).
//
// Usage:
//  - req channel carries one character of a line per transaction; code 10
//    (newline) ends the line. rsp channel carries one token or line-end
//    result per transaction; rsp_last marks the final result of a character.
//  - Lexer state is updated in the cycle a character is taken, and its
//    results are written into a three-entry output queue. rsp_valid rises
//    in the cycle after the character is taken.
//  - Throughput: one character per cycle while rsp_stall is low and each
//    character gives at most one result. A character that closes a word and
//    is itself a token or a line end gives two results; req_stall is high
//    until the second has moved to the head of the queue. The queue drain
//    rate of one result per cycle while rsp_stall is low sets this figure.
//  - req_stall is high while two or more results wait in the queue; it does
//    not depend on rsp_stall in the same cycle.
//  - When the receiver stalls, the head result holds and the queue fills;
//    the lexer stops taking characters, no result is lost.
//  - Synchronous reset empties the queue and returns the lexer to idle at
//    column 0. A newline also clears all lexer state for the next line.
module scheme_token_lexer_top #(
   parameter int LINE_MAX = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic signed [31:0] rsp_int_value,
   output logic               rsp_bool_value,
   output logic [7:0]         rsp_start_column,
   output logic [8:0]         rsp_token_length,
   output logic [1:0]         rsp_line_status,
   output logic               rsp_last
);
   import stl_pkg::*;

   // Saturation limits of column and token length
   localparam int COL_CAP = ((LINE_MAX - 1) > 255) ? 255 : (LINE_MAX - 1);
   localparam int LEN_CAP = (LINE_MAX > 256) ? 256 : LINE_MAX;
   localparam int QDEPTH  = 3;

   // Lexer state
   mode_type    mode_ff, mode_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        dot_ff, dot_in;
   logic        notnum_ff, notnum_in;
   logic        firstdig_ff, firstdig_in;
   logic [7:0]  column_ff, column_in;
   logic [7:0]  tstart_ff, tstart_in;
   logic [8:0]  tcount_ff, tcount_in;
   logic [3:0]  bmatch_ff, bmatch_in;
   logic        any_ff, any_in;

   // Output queue, slot 0 is the head
   result_type  q_ff [QDEPTH];
   result_type  q_in [QDEPTH];
   logic [1:0]  qcount_ff, qcount_in;

   logic        req_acc, rsp_pop;
   logic [7:0]  c;
   logic [8:0]  tcount_grown;
   logic [31:0] acc_step;
   result_type  word_res, char_res, res_a, res_b;
   logic        word_done, char_emit, handled, ended;
   logic [1:0]  n_res;
   logic [1:0]  q_base;

   assign c         = req_char_code;
   assign req_stall = (qcount_ff >= 2'd2);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = (qcount_ff != 2'd0);
   assign rsp_pop   = rsp_valid && !rsp_stall;

   assign tcount_grown = (tcount_ff < 9'(LEN_CAP)) ? (tcount_ff + 9'd1) : tcount_ff;
   assign acc_step     = (acc_ff * 32'd10) + {28'd0, c[3:0]};

   // Result for the word that a delimiter closes
   always_comb begin
      word_res              = '0;
      word_res.start_column = tstart_ff;
      word_res.token_length = tcount_ff;
      word_res.kind         = KIND_SYMBOL;
      case (mode_ff)
         MODE_NUM: begin
            if (notnum_ff || ((tcount_ff == 9'd1) && !firstdig_ff)) begin
               word_res.kind = KIND_SYMBOL;
            end else if (dot_ff) begin
               word_res.kind = KIND_FLOAT;
            end else begin
               word_res.kind      = KIND_INT;
               word_res.int_value = neg_ff ? (32'd0 - acc_ff) : acc_ff;
            end
         end
         MODE_HASH: begin
            if ((bmatch_ff == BM_F) || (bmatch_ff == BM_UF) || (bmatch_ff == BM_FALSE)) begin
               word_res.kind = KIND_BOOL;
            end else if ((bmatch_ff == BM_T) || (bmatch_ff == BM_UT) ||
                         (bmatch_ff == BM_TRUE)) begin
               word_res.kind       = KIND_BOOL;
               word_res.bool_value = 1'b1;
            end
         end
         default: word_res.kind = KIND_SYMBOL;
      endcase
   end

   // Next lexer state and the results of one character
   always_comb begin
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      dot_in      = dot_ff;
      notnum_in   = notnum_ff;
      firstdig_in = firstdig_ff;
      column_in   = column_ff;
      tstart_in   = tstart_ff;
      tcount_in   = tcount_ff;
      bmatch_in   = bmatch_ff;
      any_in      = any_ff;
      word_done   = 1'b0;
      char_emit   = 1'b0;
      char_res    = '0;
      handled     = 1'b0;
      ended       = 1'b0;

      case (mode_ff)
         MODE_STR: begin
            handled = 1'b1;
            if (c == CH_QUOTE) begin
               char_emit             = 1'b1;
               char_res.kind         = KIND_STRING;
               char_res.start_column = tstart_ff;
               char_res.token_length = tcount_grown;
               mode_in               = MODE_IDLE;
            end else if (c == CH_NL) begin
               char_emit            = 1'b1;
               char_res.kind        = KIND_END;
               char_res.line_status = STATUS_OPEN_STR;
               ended                = 1'b1;
            end else begin
               tcount_in = tcount_grown;
            end
         end
         MODE_COMMENT: begin
            handled = 1'b1;
            if (c == CH_NL) begin
               char_emit            = 1'b1;
               char_res.kind        = KIND_END;
               char_res.line_status = any_ff ? STATUS_OK : STATUS_EMPTY;
               ended                = 1'b1;
            end
         end
         MODE_NUM, MODE_HASH, MODE_SYM: begin
            if (is_delim(c)) begin
               word_done = 1'b1;
               mode_in   = MODE_IDLE;
            end else begin
               handled   = 1'b1;
               tcount_in = tcount_grown;
               if (mode_ff == MODE_NUM) begin
                  if (c == CH_DOT) begin
                     if (dot_ff) notnum_in = 1'b1;
                     dot_in = 1'b1;
                  end else if (!is_digit(c)) begin
                     notnum_in = 1'b1;
                  end else begin
                     acc_in = acc_step;
                  end
               end else if (mode_ff == MODE_HASH) begin
                  bmatch_in = next_match(bmatch_ff, c);
               end
            end
         end
         default: handled = 1'b0;
      endcase

      // Character seen outside any word
      if (!handled) begin
         if (c == CH_NL) begin
            char_emit            = 1'b1;
            char_res.kind        = KIND_END;
            char_res.line_status = (any_ff || word_done) ? STATUS_OK : STATUS_EMPTY;
            ended                = 1'b1;
         end else if (is_space(c)) begin
            mode_in = mode_in;
         end else if (c == CH_SEMI) begin
            mode_in = MODE_COMMENT;
         end else if (is_digit(c) || (c == CH_DOT) || (c == CH_MINUS) || (c == CH_PLUS)) begin
            mode_in     = MODE_NUM;
            tstart_in   = column_ff;
            tcount_in   = 9'd1;
            firstdig_in = is_digit(c);
            dot_in      = (c == CH_DOT);
            neg_in      = (c == CH_MINUS);
            notnum_in   = 1'b0;
            acc_in      = is_digit(c) ? {28'd0, c[3:0]} : 32'd0;
         end else if ((c == CH_OPEN) || (c == CH_CLOSE)) begin
            char_emit             = 1'b1;
            char_res.kind         = (c == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
            char_res.start_column = column_ff;
            char_res.token_length = 9'd1;
         end else if (c == CH_QUOTE) begin
            mode_in   = MODE_STR;
            tstart_in = column_ff;
            tcount_in = 9'd1;
         end else if (c == CH_HASH) begin
            mode_in   = MODE_HASH;
            tstart_in = column_ff;
            tcount_in = 9'd1;
            bmatch_in = BM_HASH;
         end else begin
            mode_in   = MODE_SYM;
            tstart_in = column_ff;
            tcount_in = 9'd1;
         end
      end

      // Any token emitted marks the line as non-empty
      if (word_done || (char_emit && (char_res.kind != KIND_END))) begin
         any_in = 1'b1;
      end

      // Column advance, or full clear at line end
      if (ended) begin
         mode_in     = MODE_IDLE;
         acc_in      = 32'd0;
         neg_in      = 1'b0;
         dot_in      = 1'b0;
         notnum_in   = 1'b0;
         firstdig_in = 1'b0;
         column_in   = 8'd0;
         tstart_in   = 8'd0;
         tcount_in   = 9'd0;
         bmatch_in   = BM_NONE;
         any_in      = 1'b0;
      end else if (column_ff < 8'(COL_CAP)) begin
         column_in = column_ff + 8'd1;
      end
   end

   // Order the results of this character and mark the final one
   always_comb begin
      res_a = word_res;
      res_b = char_res;
      n_res = 2'd0;
      if (word_done && char_emit) begin
         n_res      = 2'd2;
         res_b.last = 1'b1;
      end else if (word_done) begin
         n_res      = 2'd1;
         res_a.last = 1'b1;
      end else if (char_emit) begin
         n_res      = 2'd1;
         res_a      = char_res;
         res_a.last = 1'b1;
      end
   end

   // Queue update: shift out the head, append new results
   always_comb begin
      q_base    = qcount_ff - {1'b0, rsp_pop};
      qcount_in = q_base;
      for (int i = 0; i < QDEPTH; i++) begin
         if (rsp_pop && (i < QDEPTH - 1)) q_in[i] = q_ff[i + 1];
         else                             q_in[i] = q_ff[i];
      end
      if (req_acc) begin
         qcount_in = q_base + n_res;
         for (int i = 0; i < QDEPTH; i++) begin
            if ((n_res != 2'd0) && (2'(i) == q_base)) q_in[i] = res_a;
            if ((n_res == 2'd2) && (2'(i) == (q_base + 2'd1))) q_in[i] = res_b;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         acc_ff      <= 32'd0;
         neg_ff      <= 1'b0;
         dot_ff      <= 1'b0;
         notnum_ff   <= 1'b0;
         firstdig_ff <= 1'b0;
         column_ff   <= 8'd0;
         tstart_ff   <= 8'd0;
         tcount_ff   <= 9'd0;
         bmatch_ff   <= BM_NONE;
         any_ff      <= 1'b0;
         qcount_ff   <= 2'd0;
      end else begin
         qcount_ff <= qcount_in;
         if (req_acc) begin
            mode_ff     <= mode_in;
            acc_ff      <= acc_in;
            neg_ff      <= neg_in;
            dot_ff      <= dot_in;
            notnum_ff   <= notnum_in;
            firstdig_ff <= firstdig_in;
            column_ff   <= column_in;
            tstart_ff   <= tstart_in;
            tcount_ff   <= tcount_in;
            bmatch_ff   <= bmatch_in;
            any_ff      <= any_in;
         end
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign rsp_kind         = q_ff[0].kind;
   assign rsp_int_value    = q_ff[0].int_value;
   assign rsp_bool_value   = q_ff[0].bool_value;
   assign rsp_start_column = q_ff[0].start_column;
   assign rsp_token_length = q_ff[0].token_length;
   assign rsp_line_status  = q_ff[0].line_status;
   assign rsp_last         = q_ff[0].last;

   // Newline always leaves the lexer idle at column 0
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (c == CH_NL)) |=> ((mode_ff == MODE_IDLE) && (column_ff == 8'd0)))
      else $error("lexer state not cleared after newline");

   // Queue occupancy follows pushes and pops
   a_qcount: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (qcount_ff == ($past(qcount_ff) - {1'b0, $past(rsp_pop)} +
                          ($past(req_acc) ? $past(n_res) : 2'd0))))
      else $error("output queue count mismatch");

   // An open string or word always has at least its first character counted
   a_tcount: assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == MODE_STR) || (mode_ff == MODE_NUM) || (mode_ff == MODE_HASH) ||
       (mode_ff == MODE_SYM)) |-> (tcount_ff != 9'd0))
      else $error("token open with zero length");

   // A line end result is always the final result of its character
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_END)) |-> rsp_last)
      else $error("line end result not marked last");

endmodule
